// ===== sv/mono_framebuffer_blitter_unit_macros.svh =====
// Assertion macros for the blitter RTL.
`ifndef MONO_FRAMEBUFFER_BLITTER_UNIT_MACROS_SVH
`define MONO_FRAMEBUFFER_BLITTER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
`define MFB_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define MFB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define MFB_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define MFB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== sv/mfb_pkg.sv =====
`default_nettype none

package mfb_pkg;

    localparam int LINE_BYTES_DEF  = 100;
    localparam int FRAME_LINES_DEF = 512;

    // Widths of the item fields.
    localparam int FUNC_W  = 2;
    localparam int X_W     = 10;
    localparam int Y_W     = 9;
    localparam int EXT_W   = 10;
    // A start coordinate plus an extent needs one bit more than either.
    localparam int COORD_W = 11;

    localparam int QDEPTH  = 2;

    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_COPY  = 2'd2;

    typedef enum logic [1:0] {
        OP_READ,
        OP_WRITE,
        OP_COPY,
        OP_NOP
    } t_op;

    typedef struct packed {
        t_op                op;
        logic               bwd;
        logic               color;
        logic [COORD_W-1:0] ax;
        logic [COORD_W-1:0] ay;
        logic [COORD_W-1:0] bx;
        logic [COORD_W-1:0] by;
        logic [EXT_W-1:0]   w_m1;
        logic [EXT_W-1:0]   h_m1;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

    typedef struct packed {
        logic busy;
        logic mem_we;
        logic res_load;
    } t_back_status;

endpackage

`default_nettype wire

// ===== sv/mfb_in_if.sv =====
`default_nettype none

interface mfb_in_if
    import mfb_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [X_W-1:0]    dest_x;
    logic [Y_W-1:0]    dest_y;
    logic [X_W-1:0]    source_x;
    logic [Y_W-1:0]    source_y;
    logic [EXT_W-1:0]  rect_width;
    logic [EXT_W-1:0]  rect_height;
    logic              color;

    modport source (
        output valid, func, dest_x, dest_y, source_x, source_y,
               rect_width, rect_height, color,
        input  ready
    );
    modport sink (
        input  valid, func, dest_x, dest_y, source_x, source_y,
               rect_width, rect_height, color,
        output ready
    );
endinterface

`default_nettype wire

// ===== sv/mfb_out_if.sv =====
`default_nettype none

interface mfb_out_if;
    logic valid;
    logic ready;
    logic pixel_value;
    logic out_of_frame;

    modport source (
        output valid, pixel_value, out_of_frame,
        input  ready
    );
    modport sink (
        input  valid, pixel_value, out_of_frame,
        output ready
    );
endinterface

`default_nettype wire

// ===== sv/mono_framebuffer_blitter_unit.sv =====
// One-bit-per-pixel frame store with pixel read, pixel write and rectangle copy.
// Commands arrive as words on i_in (valid/ready); each gives exactly one result
// word on o_res carrying the pixel read back and an out-of-frame flag.
// The front classifies a command, works out its scan direction and start corner,
// and places it in a two-word queue; the back executes it against a single
// frame RAM with one read and one write port and a registered read.
// The back runs one command at a time while further commands wait in the queue.
// A read or write passes setup, pixel check and modify; a copy loops over its
// pixels, and each in-frame pixel needs a source read and a destination read on
// the one RAM read port, then a destination write; skipped pixels are not copied.
// Empty copies and unused commands go from idle straight to the result state.
// Reset empties the queue and the output register; the frame contents are not
// cleared and are undefined until written, so no clearing pass runs.
// When the receiver stalls, the result word is held in the output register and
// up to two further commands are queued before i_in.ready falls.
`default_nettype none

`include "mono_framebuffer_blitter_unit_macros.svh"

module mono_framebuffer_blitter_unit
    import mfb_pkg::*;
#(
    parameter int LINE_BYTES  = LINE_BYTES_DEF,
    parameter int FRAME_LINES = FRAME_LINES_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    mfb_in_if.sink     i_in,
    mfb_out_if.source  o_res
);
    t_cmd          w_fcmd;
    t_cmd          w_qcmd;
    logic          w_push;
    logic          w_pop;
    t_q_status     w_qstat;
    t_back_status  w_bstat;

    mfb_front u_front (
        .i_in    (i_in),
        .i_qstat (w_qstat),
        .o_push  (w_push),
        .o_cmd   (w_fcmd)
    );

    mfb_cmd_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_fcmd),
        .i_pop   (w_pop),
        .o_cmd   (w_qcmd),
        .o_stat  (w_qstat)
    );

    mfb_back #(
        .LINE_BYTES  (LINE_BYTES),
        .FRAME_LINES (FRAME_LINES)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_qcmd),
        .i_qstat (w_qstat),
        .o_pop   (w_pop),
        .o_stat  (w_bstat),
        .o_res   (o_res)
    );

    `MFB_ASSERT_IMPL(a_pop_not_empty, i_clk, i_rst_n, w_pop, !w_qstat.empty)
    `MFB_ASSERT_IMPL(a_res_room, i_clk, i_rst_n, w_bstat.res_load, !o_res.valid || o_res.ready)
    `MFB_ASSERT_NEXT(a_res_shown, i_clk, i_rst_n, w_bstat.res_load, o_res.valid)
    `MFB_ASSERT_IMPL(a_we_busy, i_clk, i_rst_n, w_bstat.mem_we, w_bstat.busy)
endmodule

`default_nettype wire

// ===== sv/mfb_ram.sv =====
`default_nettype none

module mfb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                         i_wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

`default_nettype wire

// ===== sv/mfb_front.sv =====
`default_nettype none

module mfb_front
    import mfb_pkg::*;
(
    mfb_in_if.sink          i_in,
    input  wire t_q_status  i_qstat,
    output logic            o_push,
    output t_cmd            o_cmd
);
    logic             w_bwd;
    logic [EXT_W-1:0] w_w_m1;
    logic [EXT_W-1:0] w_h_m1;
    t_op              w_op;

    assign i_in.ready = !i_qstat.full;
    assign o_push     = i_in.valid && !i_qstat.full;

    always_comb begin
        case (i_in.func)
            FUNC_READ:  w_op = OP_READ;
            FUNC_WRITE: w_op = OP_WRITE;
            FUNC_COPY:  w_op = (i_in.rect_width != '0 && i_in.rect_height != '0)
                               ? OP_COPY : OP_NOP;
            default:    w_op = OP_NOP;
        endcase
    end

    // A copy whose destination lies after its source in raster order must run
    // backwards, otherwise it would overwrite source pixels not yet read.
    assign w_bwd  = (w_op == OP_COPY) &&
                    ((i_in.dest_y > i_in.source_y) ||
                     (i_in.dest_y == i_in.source_y && i_in.dest_x > i_in.source_x));
    assign w_w_m1 = (w_op == OP_COPY) ? i_in.rect_width - EXT_W'(1) : '0;
    assign w_h_m1 = (w_op == OP_COPY) ? i_in.rect_height - EXT_W'(1) : '0;

    always_comb begin
        o_cmd.op    = w_op;
        o_cmd.bwd   = w_bwd;
        o_cmd.color = i_in.color;
        o_cmd.w_m1  = w_w_m1;
        o_cmd.h_m1  = w_h_m1;
        o_cmd.ax    = COORD_W'(i_in.source_x) + (w_bwd ? COORD_W'(w_w_m1) : '0);
        o_cmd.ay    = COORD_W'(i_in.source_y) + (w_bwd ? COORD_W'(w_h_m1) : '0);
        o_cmd.bx    = COORD_W'(i_in.dest_x)   + (w_bwd ? COORD_W'(w_w_m1) : '0);
        o_cmd.by    = COORD_W'(i_in.dest_y)   + (w_bwd ? COORD_W'(w_h_m1) : '0);
    end
endmodule

`default_nettype wire

// ===== sv/mfb_cmd_fifo.sv =====
`default_nettype none

module mfb_cmd_fifo
    import mfb_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_push,
    input  wire t_cmd       i_cmd,
    input  wire logic       i_pop,
    output t_cmd            o_cmd,
    output t_q_status       o_stat
);
    localparam int QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCW = $clog2(QDEPTH + 1);

    t_cmd             r_mem [QDEPTH];
    logic [QAW-1:0]   r_wp;
    logic [QAW-1:0]   r_rp;
    logic [QCW-1:0]   r_cnt;

    assign o_cmd        = r_mem[r_rp];
    assign o_stat.empty = (r_cnt == '0);
    assign o_stat.full  = (r_cnt == QCW'(QDEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_mem[r_wp] <= i_cmd;
                r_wp <= (r_wp == QAW'(QDEPTH - 1)) ? '0 : r_wp + QAW'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == QAW'(QDEPTH - 1)) ? '0 : r_rp + QAW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + QCW'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - QCW'(1);
            end
        end
    end
endmodule

`default_nettype wire

// ===== sv/mfb_back.sv =====
`default_nettype none

module mfb_back
    import mfb_pkg::*;
#(
    parameter int LINE_BYTES  = LINE_BYTES_DEF,
    parameter int FRAME_LINES = FRAME_LINES_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_cmd       i_cmd,
    input  wire t_q_status  i_qstat,
    output logic            o_pop,
    output t_back_status    o_stat,
    mfb_out_if.source       o_res
);
    localparam int COLS  = LINE_BYTES * 8;
    localparam int DEPTH = LINE_BYTES * FRAME_LINES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LBW   = $clog2(LINE_BYTES + 1);
    localparam int PW    = COORD_W + LBW;
    localparam logic [AW-1:0] LB_STEP = AW'(LINE_BYTES);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_PIX,
        S_RDDST,
        S_MOD,
        S_RESULT
    } t_state;

    t_state             r_state;
    t_op                r_op;
    logic               r_bwd;
    logic               r_color;
    logic [COORD_W-1:0] r_ax;
    logic [COORD_W-1:0] r_ay;
    logic [COORD_W-1:0] r_bx;
    logic [COORD_W-1:0] r_by;
    logic [COORD_W-1:0] r_ax0;
    logic [COORD_W-1:0] r_bx0;
    logic [EXT_W-1:0]   r_wm1;
    logic [EXT_W-1:0]   r_ci;
    logic [EXT_W-1:0]   r_rj;
    logic [AW-1:0]      r_sbase;
    logic [AW-1:0]      r_dbase;
    logic               r_bit;
    logic               r_pix;
    logic               r_oof;
    logic               r_out_valid;
    logic               r_out_pix;
    logic               r_out_oof;

    logic [COORD_W-1:0] n_ax;
    logic [COORD_W-1:0] n_ay;
    logic [COORD_W-1:0] n_bx;
    logic [COORD_W-1:0] n_by;
    logic [EXT_W-1:0]   n_ci;
    logic [EXT_W-1:0]   n_rj;
    logic [AW-1:0]      n_sbase;
    logic [AW-1:0]      n_dbase;

    logic [PW-1:0]      w_sprod;
    logic [PW-1:0]      w_dprod;
    logic [AW-1:0]      w_saddr;
    logic [AW-1:0]      w_daddr;
    logic [AW-1:0]      w_raddr;
    logic               w_we;
    logic [7:0]         w_rdata;
    logic [7:0]         w_wdata;
    logic               w_wbit;
    logic               w_inside;
    logic               w_last;
    logic               w_step;
    logic               w_res_load;

    function automatic logic in_frame(input logic [COORD_W-1:0] x,
                                      input logic [COORD_W-1:0] y);
        return (32'(x) < 32'(COLS)) && (32'(y) < 32'(FRAME_LINES));
    endfunction

    mfb_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_frame (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_daddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_sprod = PW'(r_ay) * PW'(LINE_BYTES);
    assign w_dprod = PW'(r_by) * PW'(LINE_BYTES);

    // Row bases wrap modulo the address width; they are only used in frame,
    // where the true value fits.
    assign w_saddr = r_sbase + AW'(r_ax[COORD_W-1:3]);
    assign w_daddr = r_dbase + AW'(r_bx[COORD_W-1:3]);
    assign w_raddr = (r_state == S_PIX && r_op == OP_COPY) ? w_saddr : w_daddr;

    assign w_inside = ((r_op != OP_COPY) || in_frame(r_ax, r_ay)) && in_frame(r_bx, r_by);
    assign w_last   = (r_ci == '0) && (r_rj == '0);
    assign w_step   = (r_state == S_MOD) || (r_state == S_PIX && !w_inside);
    assign w_we     = (r_state == S_MOD) && (r_op != OP_READ);
    assign w_res_load = (r_state == S_RESULT) && (!r_out_valid || o_res.ready);

    assign w_wbit = (r_op == OP_WRITE) ? r_color : r_bit;

    always_comb begin
        w_wdata = w_rdata;
        w_wdata[~r_bx[2:0]] = w_wbit;
    end

    always_comb begin
        n_ax    = r_ax;
        n_ay    = r_ay;
        n_bx    = r_bx;
        n_by    = r_by;
        n_ci    = r_ci;
        n_rj    = r_rj;
        n_sbase = r_sbase;
        n_dbase = r_dbase;
        if (r_ci == '0) begin
            n_ci = r_wm1;
            n_rj = r_rj - EXT_W'(1);
            n_ax = r_ax0;
            n_bx = r_bx0;
            if (r_bwd) begin
                n_ay    = r_ay - COORD_W'(1);
                n_by    = r_by - COORD_W'(1);
                n_sbase = r_sbase - LB_STEP;
                n_dbase = r_dbase - LB_STEP;
            end else begin
                n_ay    = r_ay + COORD_W'(1);
                n_by    = r_by + COORD_W'(1);
                n_sbase = r_sbase + LB_STEP;
                n_dbase = r_dbase + LB_STEP;
            end
        end else begin
            n_ci = r_ci - EXT_W'(1);
            n_ax = r_bwd ? r_ax - COORD_W'(1) : r_ax + COORD_W'(1);
            n_bx = r_bwd ? r_bx - COORD_W'(1) : r_bx + COORD_W'(1);
        end
    end

    assign o_pop = (r_state == S_IDLE) && !i_qstat.empty;

    assign o_stat.busy     = (r_state != S_IDLE);
    assign o_stat.mem_we   = w_we;
    assign o_stat.res_load = w_res_load;

    assign o_res.valid        = r_out_valid;
    assign o_res.pixel_value  = r_out_pix;
    assign o_res.out_of_frame = r_out_oof;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && o_res.ready && !w_res_load) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (!i_qstat.empty) begin
                        r_op    <= i_cmd.op;
                        r_bwd   <= i_cmd.bwd;
                        r_color <= i_cmd.color;
                        r_ax    <= i_cmd.ax;
                        r_ay    <= i_cmd.ay;
                        r_bx    <= i_cmd.bx;
                        r_by    <= i_cmd.by;
                        r_ax0   <= i_cmd.ax;
                        r_bx0   <= i_cmd.bx;
                        r_wm1   <= i_cmd.w_m1;
                        r_ci    <= i_cmd.w_m1;
                        r_rj    <= i_cmd.h_m1;
                        r_pix   <= 1'b0;
                        r_oof   <= 1'b0;
                        r_state <= (i_cmd.op == OP_NOP) ? S_RESULT : S_SETUP;
                    end
                end
                S_SETUP: begin
                    r_sbase <= AW'(w_sprod);
                    r_dbase <= AW'(w_dprod);
                    r_state <= S_PIX;
                end
                S_PIX: begin
                    if (w_inside) begin
                        r_state <= (r_op == OP_COPY) ? S_RDDST : S_MOD;
                    end else begin
                        r_oof <= 1'b1;
                    end
                end
                S_RDDST: begin
                    r_bit   <= w_rdata[~r_ax[2:0]];
                    r_state <= S_MOD;
                end
                S_MOD: begin
                    if (r_op == OP_READ) begin
                        r_pix <= w_rdata[~r_bx[2:0]];
                    end
                end
                S_RESULT: begin
                    if (w_res_load) begin
                        r_out_valid <= 1'b1;
                        r_out_pix   <= r_pix;
                        r_out_oof   <= r_oof;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (w_step) begin
                r_ax    <= n_ax;
                r_ay    <= n_ay;
                r_bx    <= n_bx;
                r_by    <= n_by;
                r_ci    <= n_ci;
                r_rj    <= n_rj;
                r_sbase <= n_sbase;
                r_dbase <= n_dbase;
                r_state <= w_last ? S_RESULT : S_PIX;
            end
        end
    end
endmodule

`default_nettype wire
